FILE: hdl/cjd_pkg.sv
`default_nettype none

package cjd_pkg;

    // Field widths of one request and one result.
    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int JD_W     = 40;

    // Internal widths.
    localparam int Y_W      = YEAR_W + 1;   // year after the January/February shift
    localparam int YPROD_W  = 27;           // 1461 * y
    localparam int YTERM_W  = YPROD_W - 2;  // floor(1461 * y / 4)
    localparam int APROD_W  = 27;           // y * reciprocal of 100
    localparam int CENT_W   = 8;            // y div 100 on the Gregorian side
    localparam int B_W      = 9;            // Gregorian correction
    localparam int MTERM_W  = 9;            // month term, at most 489
    localparam int TSEC_W   = 17;           // seconds within the day, at most 115443
    localparam int DAYS_W   = 26;           // day count and half-day count
    localparam int SECS_W   = 44;           // unsaturated result

    // Gregorian cut-over date.
    localparam int CUTOVER_YEAR  = 1582;
    localparam int CUTOVER_MONTH = 10;
    localparam int CUTOVER_DAY   = 15;

    localparam int DAYS_PER_4YEARS   = 1461;
    localparam int RECIP_100         = 5243;   // ceil(2^19 / 100)
    localparam int RECIP_100_SHIFT   = 19;
    localparam int HALFDAY_OFFSET    = 3441989; // 2 * 1720994.5
    localparam int SECONDS_PER_HALF  = 43200;
    localparam int SECONDS_PER_HOUR  = 3600;
    localparam int SECONDS_PER_MIN   = 60;

    typedef struct packed {
        logic signed [YTERM_W-1:0] year_term;
        logic signed [B_W-1:0]     greg_corr;
        logic [MTERM_W-1:0]        month_term;
        logic [DAY_W-1:0]          day;
        logic [TSEC_W-1:0]         time_sec;
    } terms_t;

    // floor(30.6001 * (m + 1)) for every four-bit month code.
    function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] r;
        case (m)
            4'd0:    r = 9'd30;
            4'd1:    r = 9'd61;
            4'd2:    r = 9'd91;
            4'd3:    r = 9'd122;
            4'd4:    r = 9'd153;
            4'd5:    r = 9'd183;
            4'd6:    r = 9'd214;
            4'd7:    r = 9'd244;
            4'd8:    r = 9'd275;
            4'd9:    r = 9'd306;
            4'd10:   r = 9'd336;
            4'd11:   r = 9'd367;
            4'd12:   r = 9'd397;
            4'd13:   r = 9'd428;
            4'd14:   r = 9'd459;
            default: r = 9'd489;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/calendar_to_julian_date_core.sv
`default_nettype none

// Converts a UTC calendar date and time into its Julian Date, given as JD times 86400 in
// whole seconds and saturated to the 40-bit signed range. The Gregorian correction applies
// from 1582-10-15 on. The block is a four-register pipeline (request register, term
// register, product register, result register): it takes one request every cycle while
// in_stall is low, and each request passes through these registers in that order.
// Every stage moves on when the stage after it is empty or emptying, so a stalled output
// still lets requests fill the empty stages ahead of it.
module calendar_to_julian_date_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [cjd_pkg::YEAR_W-1:0]    year,
    input  wire logic [cjd_pkg::MONTH_W-1:0]          month,
    input  wire logic [cjd_pkg::DAY_W-1:0]            day,
    input  wire logic [cjd_pkg::HOUR_W-1:0]           hour,
    input  wire logic [cjd_pkg::MINUTE_W-1:0]         minute,
    input  wire logic [cjd_pkg::SECOND_W-1:0]         second,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [cjd_pkg::JD_W-1:0]           jd_seconds
);
    import cjd_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;

    logic s1_ready, s2_ready, s3_ready, out_ready;

    logic signed [YEAR_W-1:0] year_reg;
    logic [MONTH_W-1:0]       month_reg;
    logic [DAY_W-1:0]         day_reg;
    logic [HOUR_W-1:0]        hour_reg;
    logic [MINUTE_W-1:0]      minute_reg;
    logic [SECOND_W-1:0]      second_reg;

    terms_t                   terms;
    terms_t                   terms_reg;
    logic signed [SECS_W-1:0] secs;
    logic signed [SECS_W-1:0] secs_reg;
    logic signed [JD_W-1:0]   jd_next;
    logic signed [JD_W-1:0]   jd_reg;
    logic                     in_range;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign s1_valid_next  = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_ready ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_ready ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    cjd_terms u_terms (
        .year   (year_reg),
        .month  (month_reg),
        .day    (day_reg),
        .hour   (hour_reg),
        .minute (minute_reg),
        .second (second_reg),
        .terms  (terms)
    );

    cjd_scale u_scale (
        .terms (terms_reg),
        .secs  (secs)
    );

    // The result fits when the bits above the 40-bit sign all copy it.
    assign in_range = (secs_reg[SECS_W-1:JD_W-1] == '0)
                   || (secs_reg[SECS_W-1:JD_W-1] == '1);

    always_comb
    begin
        if (in_range)
            jd_next = secs_reg[JD_W-1:0];
        else if (secs_reg[SECS_W-1])
            jd_next = {1'b1, {(JD_W-1){1'b0}}};
        else
            jd_next = {1'b0, {(JD_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            year_reg   <= year;
            month_reg  <= month;
            day_reg    <= day;
            hour_reg   <= hour;
            minute_reg <= minute;
            second_reg <= second;
        end
        if (s2_ready && s1_valid_reg)
            terms_reg <= terms;
        if (s3_ready && s2_valid_reg)
            secs_reg <= secs;
        if (out_ready && s3_valid_reg)
            jd_reg <= jd_next;
    end

    assign in_stall   = !s1_ready;
    assign out_valid  = out_valid_reg;
    assign jd_seconds = jd_reg;

endmodule

`default_nettype wire

FILE: hdl/cjd_terms.sv
`default_nettype none

module cjd_terms (
    input  wire logic signed [cjd_pkg::YEAR_W-1:0]   year,
    input  wire logic [cjd_pkg::MONTH_W-1:0]         month,
    input  wire logic [cjd_pkg::DAY_W-1:0]           day,
    input  wire logic [cjd_pkg::HOUR_W-1:0]          hour,
    input  wire logic [cjd_pkg::MINUTE_W-1:0]        minute,
    input  wire logic [cjd_pkg::SECOND_W-1:0]        second,
    output cjd_pkg::terms_t                          terms
);
    import cjd_pkg::*;

    logic signed [Y_W-1:0]     y;
    logic [MONTH_W-1:0]        m;
    logic signed [YPROD_W-1:0] y_ext;
    logic signed [YPROD_W-1:0] y_prod;
    logic [APROD_W-1:0]        a_prod;
    logic [CENT_W-1:0]         cent;
    logic                      greg;
    logic signed [B_W-1:0]     corr;

    // January and February belong to the previous year as months 13 and 14.
    always_comb
    begin
        if (month > MONTH_W'(2))
        begin
            y = Y_W'(year);
            m = month;
        end
        else
        begin
            y = Y_W'(year) - Y_W'(1);
            m = month + MONTH_W'(12);
        end
    end

    always_comb
    begin
        greg = 1'b0;
        if (year > YEAR_W'(CUTOVER_YEAR))
            greg = 1'b1;
        else if (year == YEAR_W'(CUTOVER_YEAR))
        begin
            if (month > MONTH_W'(CUTOVER_MONTH))
                greg = 1'b1;
            else if (month == MONTH_W'(CUTOVER_MONTH) && day >= DAY_W'(CUTOVER_DAY))
                greg = 1'b1;
        end
    end

    // Taking the top bits of 1461*y floors it divided by 4, also for negative years.
    assign y_ext  = YPROD_W'(y);
    assign y_prod = y_ext * $signed(YPROD_W'(DAYS_PER_4YEARS));

    // On the Gregorian side y is at least 1582 and fits in 14 unsigned bits.
    assign a_prod = APROD_W'(y[13:0]) * APROD_W'(RECIP_100);
    assign cent   = a_prod[RECIP_100_SHIFT +: CENT_W];
    assign corr   = greg ? (B_W'(2) - $signed({1'b0, cent})
                            + $signed({3'b000, cent[CENT_W-1:2]}))
                         : '0;

    always_comb
    begin
        terms.year_term  = y_prod[YPROD_W-1:2];
        terms.greg_corr  = corr;
        terms.month_term = month_term(m);
        terms.day        = day;
        terms.time_sec   = TSEC_W'(hour) * TSEC_W'(SECONDS_PER_HOUR)
                         + TSEC_W'(minute) * TSEC_W'(SECONDS_PER_MIN)
                         + TSEC_W'(second);
    end

endmodule

`default_nettype wire

FILE: hdl/cjd_scale.sv
`default_nettype none

module cjd_scale (
    input  wire cjd_pkg::terms_t                      terms,
    output logic signed [cjd_pkg::SECS_W-1:0]         secs
);
    import cjd_pkg::*;

    logic signed [DAYS_W-1:0] days;
    logic signed [DAYS_W-1:0] halfdays;
    logic signed [SECS_W-1:0] halfdays_ext;

    assign days = DAYS_W'(terms.year_term) + DAYS_W'(terms.greg_corr)
                + $signed(DAYS_W'(terms.month_term)) + $signed(DAYS_W'(terms.day));
    assign halfdays     = (days <<< 1) + $signed(DAYS_W'(HALFDAY_OFFSET));
    assign halfdays_ext = SECS_W'(halfdays);
    assign secs = halfdays_ext * $signed(SECS_W'(SECONDS_PER_HALF))
                + $signed(SECS_W'(terms.time_sec));

endmodule

`default_nettype wire

FILE: hdl/cjd_checker.sv
`default_nettype none

module cjd_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic signed [cjd_pkg::JD_W-1:0]    jd_seconds
);

    // A result that is held back keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(jd_seconds))
        else $error("stalled result changed or vanished");

    // With the output free, no request is ever held off.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("request stalled while output is free");

    // A request taken while the output path stays free shows up as a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("result missing four cycles after request");

    // With no requests and a free output, the pipeline drains empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && !in_stall) && !out_stall) ##1 (!(in_valid && !in_stall) && !out_stall)
        ##1 (!(in_valid && !in_stall) && !out_stall) ##1 (!(in_valid && !in_stall) && !out_stall)
        |=> !out_valid)
        else $error("result appeared without a request");

endmodule

bind calendar_to_julian_date_core cjd_checker u_cjd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .jd_seconds (jd_seconds)
);

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_PER_PHASE = 560;
    localparam int  HOLD_CYCLES      = 150;
    localparam int  DRAIN_CYCLES     = 8;
    localparam int  CYCLE_LIMIT      = 300000;
    localparam longint JD_MAX = (longint'(1) <<< (cjd_pkg::JD_W - 1)) - 1;
    localparam longint JD_MIN = -(longint'(1) <<< (cjd_pkg::JD_W - 1));

    typedef struct {
        logic signed [cjd_pkg::YEAR_W-1:0] year;
        logic [cjd_pkg::MONTH_W-1:0]       month;
        logic [cjd_pkg::DAY_W-1:0]         day;
        logic [cjd_pkg::HOUR_W-1:0]        hour;
        logic [cjd_pkg::MINUTE_W-1:0]      minute;
        logic [cjd_pkg::SECOND_W-1:0]      second;
    } date_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [cjd_pkg::JD_W-1:0] jd_seconds;
    date_req_t offered = '{default: '0};

    date_req_t date_requests[$];
    date_req_t dates_in_flight[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned dates_sent = 0;
    int unsigned dates_checked = 0;
    int unsigned saturated_seen = 0;
    int unsigned error_count = 0;

    calendar_to_julian_date_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .year       (offered.year),
        .month      (offered.month),
        .day        (offered.day),
        .hour       (offered.hour),
        .minute     (offered.minute),
        .second     (offered.second),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .jd_seconds (jd_seconds)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Julian Date times 86400 for one calendar date and time, saturated to the output width.
    function automatic logic signed [cjd_pkg::JD_W-1:0] julian_seconds(input date_req_t r);
        longint yr, mo, dy, y, m, corr, cent, yterm, mterm, halfdays, secs;
        yr = longint'(r.year);
        mo = longint'(r.month);
        dy = longint'(r.day);
        // January, February and month zero belong to the previous year.
        if (mo > 2)
        begin
            y = yr;
            m = mo;
        end
        else
        begin
            y = yr - 1;
            m = mo + 12;
        end
        corr = 0;
        if (yr > cjd_pkg::CUTOVER_YEAR
            || (yr == cjd_pkg::CUTOVER_YEAR && mo > cjd_pkg::CUTOVER_MONTH)
            || (yr == cjd_pkg::CUTOVER_YEAR && mo == cjd_pkg::CUTOVER_MONTH
                && dy >= cjd_pkg::CUTOVER_DAY))
        begin
            cent = y / 100;
            corr = 2 - cent + cent / 4;
        end
        if (y >= 0)
            yterm = (y * 1461) / 4;
        else
            yterm = -((3 - y * 1461) / 4);
        mterm = ((m + 1) * 306001) / 10000;
        halfdays = 2 * (corr + yterm + mterm + dy) + 3441989;
        secs = halfdays * 43200 + longint'(r.hour) * 3600 + longint'(r.minute) * 60
               + longint'(r.second);
        if (secs > JD_MAX)
            secs = JD_MAX;
        if (secs < JD_MIN)
            secs = JD_MIN;
        return secs[cjd_pkg::JD_W-1:0];
    endfunction

    task automatic add_date(input int y, input int mo, input int d, input int h,
                            input int mi, input int s);
        date_req_t r;
        r.year   = cjd_pkg::YEAR_W'(y);
        r.month  = cjd_pkg::MONTH_W'(mo);
        r.day    = cjd_pkg::DAY_W'(d);
        r.hour   = cjd_pkg::HOUR_W'(h);
        r.minute = cjd_pkg::MINUTE_W'(mi);
        r.second = cjd_pkg::SECOND_W'(s);
        date_requests.push_back(r);
    endtask

    // Mostly well-formed dates, some clustered around the calendar reform or year zero,
    // the rest with every field drawn over its full bit range.
    task automatic add_random_dates(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                add_date(int'($urandom_range(9999 + 4712)) - 4712, $urandom_range(12, 1),
                         $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                         $urandom_range(60));
            else if (pick < 75)
                add_date(cjd_pkg::CUTOVER_YEAR - 1 + int'($urandom_range(2)),
                         $urandom_range(12, 1), $urandom_range(31, 1), $urandom_range(23),
                         $urandom_range(59), $urandom_range(60));
            else if (pick < 85)
                add_date(int'($urandom_range(8)) - 4, $urandom_range(12, 1),
                         $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                         $urandom_range(60));
            else
                add_date(int'($urandom_range(32767)), $urandom_range(15), $urandom_range(31),
                         $urandom_range(31), $urandom_range(63), $urandom_range(63));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_dates
        date_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                dates_in_flight.push_back(offered);
                dates_sent++;
            end
            if (date_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = date_requests.pop_front();
                offered <= nxt;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        date_req_t req;
        logic signed [cjd_pkg::JD_W-1:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (dates_in_flight.size() == 0)
                begin
                    $error("jd_seconds: result %0d with no request outstanding", jd_seconds);
                    error_count++;
                end
                else
                begin
                    req = dates_in_flight.pop_front();
                    want = julian_seconds(req);
                    if (jd_seconds !== want)
                    begin
                        $error("jd_seconds for %0d-%0d-%0d %0d:%0d:%0d: expected %0d, actual %0d",
                               req.year, req.month, req.day, req.hour, req.minute, req.second,
                               want, jd_seconds);
                        error_count++;
                    end
                    if (want == JD_MAX)
                        saturated_seen++;
                    dates_checked++;
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, dates_in_flight.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        // Directed requests: range edges, the calendar reform, month wrap cases,
        // out-of-range fields and saturation.
        add_date(-4712, 1, 1, 12, 0, 0);
        add_date(-4712, 1, 1, 0, 0, 0);
        add_date(1582, 10, 4, 23, 59, 59);
        add_date(1582, 10, 14, 0, 0, 0);
        add_date(1582, 10, 15, 0, 0, 0);
        add_date(1582, 11, 1, 6, 30, 0);
        add_date(1582, 2, 28, 0, 0, 0);
        add_date(1583, 1, 1, 0, 0, 0);
        add_date(1582, 13, 1, 0, 0, 0);
        add_date(1582, 15, 31, 0, 0, 0);
        add_date(2000, 1, 1, 12, 0, 0);
        add_date(2000, 0, 15, 0, 0, 0);
        add_date(1900, 3, 1, 0, 0, 0);
        add_date(0, 2, 29, 0, 0, 0);
        add_date(0, 3, 1, 0, 0, 0);
        add_date(-1, 12, 31, 23, 59, 60);
        add_date(9999, 12, 31, 23, 59, 60);
        add_date(1970, 1, 0, 31, 63, 63);
        add_date(16383, 15, 31, 31, 63, 63);
        add_date(16383, 0, 0, 0, 0, 0);
        add_date(-16384, 0, 0, 0, 0, 0);
        add_date(-16384, 15, 31, 31, 63, 63);
        add_date(8000, 6, 15, 12, 0, 0);
        add_date(-4713, 1, 1, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (date_requests.size() != 0)
            @(posedge clk);

        send_idle_pct <= 32;
        recv_stall_pct <= 50;
        add_random_dates(RANDOM_PER_PHASE);
        while (date_requests.size() != 0)
            @(posedge clk);

        send_idle_pct <= 50;
        recv_stall_pct <= 32;
        add_random_dates(RANDOM_PER_PHASE);
        while (date_requests.size() != 0)
            @(posedge clk);

        // Back-to-back requests against a long output hold-off fill the pipeline.
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        hold_request <= 1'b1;
        add_random_dates(RANDOM_PER_PHASE);

        while (date_requests.size() != 0 || in_valid || dates_in_flight.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps, %0d results compared, %0d saturated, %0d mismatches.",
                 dates_sent, dates_checked, saturated_seen, error_count);
        $display("Covered the reform cut-over, month wrap, out-of-range fields and backpressure.");
        if (error_count == 0 && dates_in_flight.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
